// ===== rtl/core/crd_pkg.sv =====
// crd_pkg: shared types and constants for the checksummed record deframer
// holds the result kind codes, the queue item type and the register indexes
// no dependencies
`timescale 1ns / 1ps

package crd_pkg;

    // result kind codes as they appear on m_tuser
    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BADSUM  = 3'd2,
        KIND_NOTERM  = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_EARLY   = 3'd5,
        KIND_ENDMARK = 3'd6,
        KIND_SHORT   = 3'd7
    } kind_t;

    // one result item as it travels from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [7:0]  index;
        logic [31:0] start;
        logic        done;
    } item_t;

    // write side of the queue
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_wr_t;

    // read side of the queue
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_rd_t;

    // configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_END_BYTE   = 1'b1;

    // register reset values
    localparam logic [7:0] START_BYTE_RST = 8'd68;
    localparam logic [7:0] END_BYTE_RST   = 8'd13;

endpackage

// ===== rtl/core/checksummed_record_deframer.sv =====
// checksummed_record_deframer: top level of the length-prefixed record deframer
// depends on crd_pkg, crd_front, crd_queue, crd_back
//
//   channel  | direction | handshake          | contents
//   s_       | in        | s_tvalid/s_tready  | tdata data_byte, tlast end_of_input
//   m_       | out       | m_tvalid/m_tready  | tdata value/index/start, tuser kind,
//            |           |                    | tlast record_done
//   cfg_     | in        | cfg_wr_en          | cfg_addr register index, cfg_wdata
//
// one input beat per cycle while s_tready is high; each beat is classified combinationally by the front
// a result enters the queue at the edge that accepts its input beat and moves from
// the queue head into the output register, which drives m_tvalid, when that is free
// reset is synchronous and clears all control state; no clearing pass is needed
// s_tready drops only while the result queue is full, so a stalled m_ side
// backs up at most QUEUE_DEPTH results plus the output register before input stops
`timescale 1ns / 1ps

module checksummed_record_deframer
    import crd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_input
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_value, [15:8] payload_index,
                                   // [47:16] record_start
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // record_done
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    crd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    crd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    crd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/crd_front.sv =====
// crd_front: accepts stream beats, tracks record framing and checksum
// pushes at most one result item per beat into the queue
// depends on crd_pkg
`timescale 1ns / 1ps

module crd_front
    import crd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        q_full,
    output q_wr_t       q_wr
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LEN  = 5'b00010,
        ST_BODY = 5'b00100,
        ST_TERM = 5'b01000,
        ST_HALT = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  blen_reg, blen_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] start_off_reg, start_off_next;
    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;

    logic        accept;
    logic [31:0] offset_inc;
    logic [7:0]  pay_idx;
    logic [7:0]  pay_len;
    logic [7:0]  sum_add;
    item_t       item;
    logic        emit;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // saturating stream offset and derived record values
    assign offset_inc = (offset_reg == 32'hFFFF_FFFF) ? offset_reg : offset_reg + 32'd1;
    assign pay_idx    = blen_reg - left_reg;
    assign pay_len    = (blen_reg == 8'd0) ? 8'd0 : blen_reg - 8'd1;
    assign sum_add    = sum_reg + s_tdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_START_BYTE: start_byte_reg <= cfg_wdata;
                CFG_END_BYTE:   end_byte_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // framing state machine
    always_comb begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        blen_next      = blen_reg;
        offset_next    = offset_reg;
        start_off_next = start_off_reg;
        emit           = 1'b0;
        item.kind      = KIND_PAYLOAD;
        item.value     = sum_reg;
        item.index     = pay_len;
        item.start     = start_off_reg;
        item.done      = 1'b1;
        if (accept && phase_reg != ST_HALT) begin
            if (s_tlast) begin
                phase_next = ST_HALT;
                if (phase_reg != ST_IDLE) begin
                    emit      = 1'b1;
                    item.kind = KIND_EARLY;
                end
            end else begin
                unique case (phase_reg)
                    ST_IDLE: begin
                        if (s_tdata == start_byte_reg) begin
                            start_off_next = offset_reg;
                            sum_next       = 8'd0;
                            left_next      = 8'd0;
                            blen_next      = 8'd0;
                            offset_next    = offset_inc;
                            phase_next     = ST_LEN;
                        end else begin
                            emit       = 1'b1;
                            item.kind  = (s_tdata == 8'd0) ? KIND_ENDMARK : KIND_UNKNOWN;
                            item.value = 8'd0;
                            item.index = 8'd0;
                            item.start = offset_reg;
                            phase_next = ST_HALT;
                        end
                    end
                    ST_LEN: begin
                        blen_next   = s_tdata;
                        left_next   = s_tdata;
                        sum_next    = s_tdata;
                        offset_next = offset_inc;
                        phase_next  = (s_tdata == 8'd0) ? ST_TERM : ST_BODY;
                    end
                    ST_BODY: begin
                        sum_next    = sum_add;
                        left_next   = left_reg - 8'd1;
                        offset_next = offset_inc;
                        if (left_reg == 8'd1) begin
                            // checksum byte closes the body, no payload beat
                            phase_next = ST_TERM;
                        end else begin
                            emit       = 1'b1;
                            item.kind  = KIND_PAYLOAD;
                            item.value = s_tdata;
                            item.index = pay_idx;
                            item.done  = 1'b0;
                        end
                    end
                    ST_TERM: begin
                        emit = 1'b1;
                        if (s_tdata != end_byte_reg) begin
                            item.kind  = KIND_NOTERM;
                            phase_next = ST_HALT;
                        end else begin
                            offset_next = offset_inc;
                            phase_next  = ST_IDLE;
                            priority if (sum_reg != 8'd0) begin
                                item.kind = KIND_BADSUM;
                            end else if (blen_reg <= 8'd1) begin
                                item.kind = KIND_SHORT;
                            end else begin
                                item.kind = KIND_GOOD;
                            end
                        end
                    end
                    default: phase_next = ST_HALT;
                endcase
            end
        end
    end

    assign q_wr.valid = emit;
    assign q_wr.item  = item;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ST_IDLE;
            sum_reg       <= 8'd0;
            left_reg      <= 8'd0;
            blen_reg      <= 8'd0;
            offset_reg    <= 32'd0;
            start_off_reg <= 32'd0;
        end else begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            blen_reg      <= blen_next;
            offset_reg    <= offset_next;
            start_off_reg <= start_off_next;
        end
    end

    // a halted block stays silent
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == ST_HALT |-> !q_wr.valid)
        else $error("result pushed while halted");

    // only payload beats leave a record open
    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.valid |-> (q_wr.item.done == (q_wr.item.kind != KIND_PAYLOAD)))
        else $error("record_done does not match kind");

    // end of input always halts
    a_eoi_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> phase_reg == ST_HALT)
        else $error("end of input did not halt");

endmodule

// ===== rtl/core/crd_queue.sv =====
// crd_queue: small fifo of result items between front and back
// depends on crd_pkg
`timescale 1ns / 1ps

module crd_queue
    import crd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t q_wr,
    output logic  q_full,
    output q_rd_t q_rd,
    input  logic  q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full     = (count_reg == CNT_W'(DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.item  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (q_wr.valid) begin
            mem[wr_ptr_reg] <= q_wr.item;
        end
    end

    // occupancy
    always_comb begin
        unique case ({q_wr.valid, q_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers, wrapping at the last entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_wr.valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.valid |-> !q_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_rd.valid)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr.valid && !q_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/crd_back.sv =====
// crd_back: output register stage, drains the queue onto the master channel
// depends on crd_pkg
`timescale 1ns / 1ps

module crd_back
    import crd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  q_rd_t       q_rd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic  m_valid_reg;
    item_t m_item_reg;

    // load the output stage when it is empty or being drained
    assign q_pop = q_rd.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= q_rd.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_item_reg <= q_rd.item;
        end
    end

    // beat packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_item_reg.start, m_item_reg.index, m_item_reg.value};
    assign m_tuser  = m_item_reg.kind;
    assign m_tlast  = m_item_reg.done;

endmodule
